>>> rtl/core/utf8u_pkg.sv
// Shared types and helpers for the UTF-8 to backslash-u escape converter.
// Used by utf8u_front, utf8u_queue, utf8u_back and utf8_to_unicode_escape.
package utf8u_pkg;

  // Input transfer: one byte of text plus end-of-text mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_t;

  // Output transfer: one character plus end-of-run mark
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_t;

  localparam int CodeW  = 21;
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // Index of the last character of an escape with 4, 5 or 6 hex digits
  localparam logic [2:0] LastIdx4 = 3'd5;
  localparam logic [2:0] LastIdx5 = 3'd6;
  localparam logic [2:0] LastIdx6 = 3'd7;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharU      = 8'h75;

  // One unit of work for the back end
  typedef struct packed {
    logic             is_escape; // 0: pass code[7:0] as is
    logic [CodeW-1:0] code;
    logic [2:0]       last_idx;  // index of the final character of this job
  } job_t;

  // Uppercase hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

>>> rtl/core/utf8u_front.sv
// Front end: UTF-8 sequence decoder. Classifies each byte, assembles code points
// and hands finished jobs to the queue. Depends on utf8u_pkg.
module utf8u_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  utf8u_pkg::in_t     in_item,
  output logic               job_valid,
  input  logic               job_full,
  output utf8u_pkg::job_t    job
);

  logic [1:0]                    bytes_pending;
  logic [1:0]                    bytes_pending_next;
  logic [utf8u_pkg::CodeW-1:0]   code_accum;
  logic [utf8u_pkg::CodeW-1:0]   code_accum_next;
  logic [utf8u_pkg::CodeW-1:0]   cp;
  logic                          accept;
  logic                          finished;
  logic                          pass;
  logic [7:0]                    b;

  assign in_stall = job_full;
  assign accept   = in_valid && !job_full;
  assign b        = in_item.in_byte;

  // Byte classification and accumulation
  always_comb begin
    bytes_pending_next = bytes_pending;
    code_accum_next    = code_accum;
    finished           = 1'b0;
    pass               = 1'b0;
    if (bytes_pending != 2'd0) begin
      code_accum_next    = {code_accum[utf8u_pkg::CodeW-7:0], b[5:0]};
      bytes_pending_next = bytes_pending - 2'd1;
      finished           = (bytes_pending == 2'd1);
    end else if (b[7] == 1'b0) begin
      pass = 1'b1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      code_accum_next    = {16'd0, b[4:0]};
      bytes_pending_next = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      code_accum_next    = {17'd0, b[3:0]};
      bytes_pending_next = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      code_accum_next    = {18'd0, b[2:0]};
      bytes_pending_next = 2'd3;
    end else begin
      // stray byte: code point zero
      code_accum_next = '0;
      finished        = 1'b1;
    end
    cp = code_accum_next;
    if (finished || in_item.text_end) begin
      code_accum_next = '0;
    end
    if (in_item.text_end) begin
      bytes_pending_next = 2'd0;
    end
  end

  // Job build
  always_comb begin
    job.is_escape = finished;
    if (pass) begin
      job.code     = {13'd0, b};
      job.last_idx = 3'd0;
    end else begin
      job.code = cp;
      if (cp > 21'hFFFFF) begin
        job.last_idx = utf8u_pkg::LastIdx6;
      end else if (cp > 21'hFFFF) begin
        job.last_idx = utf8u_pkg::LastIdx5;
      end else begin
        job.last_idx = utf8u_pkg::LastIdx4;
      end
    end
  end

  assign job_valid = in_valid && (pass || finished);

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      code_accum    <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      code_accum    <= code_accum_next;
    end
  end

endmodule

>>> rtl/core/utf8u_queue.sv
// Job queue between decoder and serializer: small register FIFO.
// Depends on utf8u_pkg.
module utf8u_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  utf8u_pkg::job_t  push_job,
  output logic             full,
  output logic             q_valid,
  input  logic             pop,
  output utf8u_pkg::job_t  q_job
);

  utf8u_pkg::job_t              entries [utf8u_pkg::QDepth];
  logic [utf8u_pkg::QPtrW-1:0]  wr_ptr;
  logic [utf8u_pkg::QPtrW-1:0]  rd_ptr;
  logic [utf8u_pkg::QPtrW:0]    count;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count == (utf8u_pkg::QPtrW+1)'(utf8u_pkg::QDepth));
  assign q_valid = (count != '0);
  assign q_job   = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + (utf8u_pkg::QPtrW)'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + (utf8u_pkg::QPtrW)'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (utf8u_pkg::QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (utf8u_pkg::QPtrW+1)'(1);
      end
    end
  end

endmodule

>>> rtl/core/utf8u_back.sv
// Back end: serializes one job into output characters, one per cycle while the
// output is not stalled, into a registered output stage. Depends on utf8u_pkg.
module utf8u_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  utf8u_pkg::job_t  q_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output utf8u_pkg::out_t  out_item
);

  logic             cur_valid;
  utf8u_pkg::job_t  cur;
  logic [2:0]       idx;
  logic [2:0]       digit;
  logic [3:0]       nib;
  logic [7:0]       ch;
  logic             is_last;
  logic             load;
  logic             take_next;

  assign is_last   = (idx == cur.last_idx);
  assign load      = cur_valid && (!out_valid || !out_stall);
  assign take_next = !cur_valid || (load && is_last);
  assign pop       = take_next && q_valid;
  assign digit     = cur.last_idx - idx;

  // Nibble for the current hex digit position
  always_comb begin
    case (digit)
      3'd0:    nib = cur.code[3:0];
      3'd1:    nib = cur.code[7:4];
      3'd2:    nib = cur.code[11:8];
      3'd3:    nib = cur.code[15:12];
      3'd4:    nib = cur.code[19:16];
      3'd5:    nib = {3'b000, cur.code[20]};
      default: nib = 4'd0;
    endcase
  end

  // Character select
  always_comb begin
    if (!cur.is_escape) begin
      ch = cur.code[7:0];
    end else if (idx == 3'd0) begin
      ch = utf8u_pkg::CharBslash;
    end else if (idx == 3'd1) begin
      ch = utf8u_pkg::CharU;
    end else begin
      ch = utf8u_pkg::hex_char(nib);
    end
  end

  // Current job and character index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (take_next) begin
        cur_valid <= q_valid;
        idx       <= 3'd0;
      end else if (load) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_next) begin
      cur <= q_job;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.out_char <= ch;
      out_item.run_last <= is_last;
    end
  end

endmodule

>>> rtl/core/utf8_to_unicode_escape.sv
// UTF-8 to backslash-u escape converter, top level.
// Depends on utf8u_pkg, utf8u_front, utf8u_queue and utf8u_back.
//
// Takes one text byte per cycle whenever the job queue has room. ASCII bytes
// come out unchanged; each finished multi-byte sequence or stray byte comes
// out as a backslash, 'u' and 4 to 6 uppercase hex digits (6 to 8 characters),
// one character per cycle from the serializer while the output is not stalled.
// Pure ASCII streams flow at 1 byte per cycle while the output is not stalled;
// escape runs are limited by the serializer at one character per cycle, and a
// 4-entry job queue lets input continue while a run drains. Lead bytes and
// continuation bytes that do not finish a sequence produce no output. An
// unfinished sequence at the end of the text is dropped.
module utf8_to_unicode_escape (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  utf8u_pkg::in_t   in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output utf8u_pkg::out_t  out_item
);

  logic             job_valid;
  logic             job_full;
  utf8u_pkg::job_t  job;
  logic             q_valid;
  logic             pop;
  utf8u_pkg::job_t  q_job;

  utf8u_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job_full  (job_full),
    .job       (job)
  );

  utf8u_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_valid),
    .push_job (job),
    .full     (job_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_job    (q_job)
  );

  utf8u_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for utf8_to_unicode_escape: drives UTF-8 byte streams with
// random gaps and output stalls, predicts the escape characters and checks each transfer.
// Depends on utf8u_pkg and the utf8_to_unicode_escape RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 16;
  localparam int ByteTarget = 325;

  // Lead byte tags
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;
  localparam logic [1:0] ContTag  = 2'b10;

  // Predicts the escape stream and checks what the block sends out
  class escape_checker;
    utf8u_pkg::out_t expected_chars[$];
    logic [1:0]      seq_left;
    logic [20:0]     code_pt;
    int              errors;

    function new();
      seq_left = '0;
      code_pt = '0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("tb_top: mismatch: %s", msg);
      errors++;
    endtask

    function int waiting();
      return expected_chars.size();
    endfunction

    function void push_char(input logic [7:0] ch, input bit last);
      utf8u_pkg::out_t c;
      c.out_char = ch;
      c.run_last = last;
      expected_chars.insert(expected_chars.size(), c);
    endfunction

    // Backslash, 'u', then 4 to 6 uppercase hex digits
    function void push_escape(input logic [20:0] cp);
      int digits;
      logic [3:0] nib;
      digits = (cp > 21'hFFFFF) ? 6 : ((cp > 21'hFFFF) ? 5 : 4);
      push_char(utf8u_pkg::CharBslash, 1'b0);
      push_char(utf8u_pkg::CharU, 1'b0);
      for (int d = digits - 1; d >= 0; d--) begin
        nib = 4'(cp >> (4 * d));
        if (nib < 4'd10) begin
          push_char("0" + 8'(nib), d == 0);
        end else begin
          push_char("A" + 8'(nib) - 8'd10, d == 0);
        end
      end
    endfunction

    // Called on every accepted input transfer
    function void take_byte(input utf8u_pkg::in_t item);
      logic [7:0] b;
      bit done;
      b = item.in_byte;
      done = 1'b0;
      if (seq_left != 0) begin
        // any byte counts as a continuation while a sequence is open
        code_pt = {code_pt[14:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        done = (seq_left == 0);
      end else if (!b[7]) begin
        push_char(b, 1'b1);
      end else if (b[7:5] == Lead2Tag) begin
        code_pt = 21'(b[4:0]);
        seq_left = 2'd1;
      end else if (b[7:4] == Lead3Tag) begin
        code_pt = 21'(b[3:0]);
        seq_left = 2'd2;
      end else if (b[7:3] == Lead4Tag) begin
        code_pt = 21'(b[2:0]);
        seq_left = 2'd3;
      end else begin
        // stray byte: code point zero
        code_pt = '0;
        done = 1'b1;
      end
      if (done) begin
        push_escape(code_pt);
        code_pt = '0;
      end
      // end of text drops an open sequence
      if (item.text_end) begin
        seq_left = '0;
        code_pt = '0;
      end
    endfunction

    // Called on every accepted output transfer
    task check_char(input utf8u_pkg::out_t got);
      utf8u_pkg::out_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h last %b", got.out_char, got.run_last));
      end else begin
        want = expected_chars.pop_front();
        if (got.out_char !== want.out_char) begin
          report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
        end
        if (got.run_last !== want.run_last) begin
          report($sformatf("run_last %b, want %b (char %h)",
                           got.run_last, want.run_last, want.out_char));
        end
      end
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  utf8u_pkg::in_t  in_item = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  utf8u_pkg::out_t out_item;

  escape_checker sb = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int stall_left = 0;
  int bytes_sent = 0;
  int cycle_count = 0;

  utf8_to_unicode_escape i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Output side: check each transfer, then stall for a random count
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      sb.check_char(out_item);
      stall_left = rx_steady ? 0 : $urandom_range(0, 10);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= (stall_left != 0);
    end
  end

  // One input transfer after a random gap; valid stays high when there is no gap
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    utf8u_pkg::in_t item;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    item.in_byte = b;
    item.text_end = last;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(item);
    bytes_sent++;
  endtask

  // Hold off the input until every predicted char has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
  endtask

  function automatic bit draw_end();
    return ($urandom_range(0, 15) == 0);
  endfunction

  // One random unit: mostly well-formed text, some strays and broken sequences
  task automatic send_random_unit();
    int kind;
    int n;
    int m;
    bit cut;
    logic [7:0] lead;
    kind = $urandom_range(0, 99);
    n = $urandom_range(1, 3);
    case (n)
      1: lead = {Lead2Tag, 5'($urandom)};
      2: lead = {Lead3Tag, 4'($urandom)};
      default: lead = {Lead4Tag, 3'($urandom)};
    endcase
    if (kind < 40) begin
      send_byte(8'($urandom_range(0, 127)), draw_end());
    end else if (kind < 75) begin
      send_byte(lead, 1'b0);
      for (int k = 0; k < n; k++) begin
        send_byte({ContTag, 6'($urandom)}, (k == n - 1) ? draw_end() : 1'b0);
      end
    end else if (kind < 85) begin
      // truncated sequence, often closed by end of text
      m = $urandom_range(0, n - 1);
      cut = $urandom_range(0, 1);
      send_byte(lead, cut && (m == 0));
      for (int k = 0; k < m; k++) begin
        send_byte({ContTag, 6'($urandom)}, cut && (k == m - 1));
      end
    end else if (kind < 95) begin
      if ($urandom_range(0, 1) == 0) begin
        send_byte(8'($urandom_range(8'h80, 8'hBF)), draw_end());
      end else begin
        send_byte(8'($urandom_range(8'hF8, 8'hFF)), draw_end());
      end
    end else begin
      send_byte(8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    // two, three and four byte sequences
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // largest value, six hex digits
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // stray bytes
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // ASCII byte taken as a continuation
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);
    // open sequence dropped at end of text
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // end of text on ASCII, on a completing byte and on a stray
    send_byte(8'h41, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hF8, 1'b1);

    wait_drained();

    // Random text in phases; some phases run without gaps or stalls
    while (bytes_sent < ByteTarget) begin
      if ($urandom_range(0, 29) == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_steady = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 59) == 0) begin
        wait_drained();
      end
      send_random_unit();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.waiting() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/utf8u_pkg.sv
rtl/core/utf8u_front.sv
rtl/core/utf8u_queue.sv
rtl/core/utf8u_back.sv
rtl/core/utf8_to_unicode_escape.sv
tb/tb_top.sv
